// File: hw/rtl/olad_pkg.sv
package olad_pkg;

  // Default list depth and fixed field widths
  localparam int DEPTH_DEF = 32;
  localparam int ID_W      = 32;
  localparam int CNT_OUT_W = 6;
  localparam int DATA_O_W  = 40;

  // Item kinds
  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_APPENDED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_HEAD      = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_REMOVED   = 3'd5
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_SCAN,
    S_SHIFT,
    S_RESULT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    append;   // write incoming id at the tail, count up
    logic    take;     // latch reference id, point at the head
    logic    advance;  // step the pointer, keep current entry as previous
    logic    hit;      // capture previous entry as the removed id
    logic    move;     // copy current entry one place towards the head
    logic    shrink;   // count down
    logic    emit;     // load the output register
    status_t status;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic match;
    logic last;
    logic at_end;
    logic out_free;
  } stat_t;

endpackage

// File: hw/rtl/ordered_list_append_delete_before_unit.sv
// An append (also one refused on a full list) or an early-exit delete on an empty list goes
// straight to the result state. A delete-before does one memory read per entry during the search,
// then one read and one write per entry while the gap closes, on separate memory ports.
// One transaction at a time; the next is accepted once the controller is idle again.
// Reset (rst, synchronous, active high) empties the list and drops any pending result.
module ordered_list_append_delete_before_unit #(
  parameter int DEPTH = olad_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [olad_pkg::ID_W-1:0]     s_axis_tdata,   // [31:0] step_id
  input  logic                          s_axis_tuser,   // [0] kind
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [olad_pkg::DATA_O_W-1:0] m_axis_tdata,   // [31:0] removed_id, [37:32] entry_count
  output logic [2:0]                    m_axis_tuser    // [2:0] status
);
  import olad_pkg::*;

  cmd_t  cmd;
  stat_t st;

  olad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_kind  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  olad_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .in_id      (s_axis_tdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_status (m_axis_tuser)
  );

endmodule

// File: hw/rtl/olad_ctrl.sv
module olad_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_kind,
  output logic          in_ready,
  input  olad_pkg::stat_t st,
  output olad_pkg::cmd_t  cmd
);
  import olad_pkg::*;

  state_t  state, state_next;
  status_t res, res_next;

  // State and result code registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res   <= ST_APPENDED;
    end else begin
      state <= state_next;
      res   <= res_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    res_next    = res;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.status  = res;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == KIND_APPEND) begin
            if (st.full) begin
              res_next = ST_FULL;
            end else begin
              cmd.append = 1'b1;
              res_next   = ST_APPENDED;
            end
            state_next = S_RESULT;
          end else if (st.empty) begin
            res_next   = ST_EMPTY;
            state_next = S_RESULT;
          end else begin
            cmd.take   = 1'b1;
            state_next = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        if (st.match) begin
          res_next   = ST_HEAD;
          state_next = S_RESULT;
        end else if (st.last) begin
          res_next   = ST_NOT_FOUND;
          state_next = S_RESULT;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (st.match) begin
          cmd.hit     = 1'b1;
          cmd.move    = 1'b1;
          cmd.advance = 1'b1;
          state_next  = S_SHIFT;
        end else if (st.last) begin
          res_next   = ST_NOT_FOUND;
          state_next = S_RESULT;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_SHIFT: begin
        if (st.at_end) begin
          cmd.shrink = 1'b1;
          res_next   = ST_REMOVED;
          state_next = S_RESULT;
        end else begin
          cmd.move    = 1'b1;
          cmd.advance = 1'b1;
        end
      end
      S_RESULT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/olad_store.sv
module olad_store #(
  parameter int DEPTH = olad_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  olad_pkg::cmd_t                 cmd,
  output olad_pkg::stat_t                st,
  input  logic [olad_pkg::ID_W-1:0]      in_id,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [olad_pkg::DATA_O_W-1:0]  out_data,
  output logic [2:0]                     out_status
);
  import olad_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [ID_W-1:0] mem [DEPTH];
  logic [ID_W-1:0] rdata;
  logic [ID_W-1:0] id_ref;
  logic [ID_W-1:0] prev;
  logic [ID_W-1:0] removed;
  logic [CW-1:0]   ptr, ptr_next, ptr_dec;
  logic [CW-1:0]   fill, fill_last;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [ID_W-1:0] wr_data;
  logic            wr_en;

  // Pointer steering; read data follows the pointer register while the pointer is below DEPTH
  always_comb begin
    if (cmd.take) begin
      ptr_next = '0;
    end else if (cmd.advance) begin
      ptr_next = ptr + CW'(1);
    end else begin
      ptr_next = ptr;
    end
  end

  assign rd_addr   = (ptr_next < CW'(DEPTH)) ? ptr_next[AW-1:0] : '0;
  assign ptr_dec   = ptr - CW'(1);
  assign fill_last = fill - CW'(1);

  // Write port: tail append or gap closing
  assign wr_en   = cmd.append | cmd.move;
  assign wr_addr = cmd.append ? fill[AW-1:0] : ptr_dec[AW-1:0];
  assign wr_data = cmd.append ? in_id : rdata;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  // Pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      fill <= '0;
    end else begin
      ptr <= ptr_next;
      if (cmd.append) begin
        fill <= fill + CW'(1);
      end else if (cmd.shrink) begin
        fill <= fill_last;
      end
    end
  end

  // Reference, previous entry and removed id
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      id_ref <= in_id;
    end
    if (cmd.advance) begin
      prev <= rdata;
    end
    if (cmd.hit) begin
      removed <= prev;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= cmd.status;
      out_data   <= {2'b00, CNT_OUT_W'(fill),
                     (cmd.status == ST_REMOVED) ? removed : {ID_W{1'b0}}};
    end
  end

  // Status towards the controller
  assign st.full     = (fill == CW'(DEPTH));
  assign st.empty    = (fill == '0);
  assign st.match    = (rdata == id_ref);
  assign st.last     = (ptr == fill_last);
  assign st.at_end   = (ptr >= fill);
  assign st.out_free = ~out_valid | out_ready;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= CW'(DEPTH))
    else $error("fill count beyond depth");
  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> fill != CW'(DEPTH))
    else $error("append into a full list");
  a_shrink_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.shrink |-> fill != '0)
    else $error("removal from an empty list");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("output overwritten before taken");
  a_move_inside: assert property (@(posedge clk) disable iff (rst)
    cmd.move |-> (ptr != '0 && ptr < fill))
    else $error("gap closing outside the list");
`endif

endmodule

// File: sim/testbench.sv
module testbench;
  import olad_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEF;

  // One expected result transaction
  typedef struct {
    status_t     status;
    logic [31:0] removed_id;
    logic [5:0]  entry_count;
  } list_outcome_t;

  // Scoreboard: mirror of the list contents plus the queue of pending outcomes
  class list_scoreboard;
    logic [31:0]   held_ids[LIST_DEPTH];
    int unsigned   held_count;
    list_outcome_t pending[$];
    int            errors;
    int            seen[6];

    function new();
      held_count = 0;
      errors     = 0;
      foreach (seen[k]) seen[k] = 0;
    endfunction

    function logic [31:0] held(input int unsigned idx);
      return held_ids[idx];
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    // Apply one accepted transaction to the mirror and queue its outcome
    function void note_item(input logic kind, input logic [31:0] key);
      list_outcome_t o;
      int unsigned   hit;
      o.removed_id = '0;
      hit = 0;
      if (kind == KIND_APPEND) begin
        if (held_count >= LIST_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          held_ids[held_count] = key;
          held_count++;
          o.status = ST_APPENDED;
        end
      end else if (held_count == 0) begin
        o.status = ST_EMPTY;
      end else if (held_ids[0] == key) begin
        o.status = ST_HEAD;
      end else begin
        // first match from the second entry on
        for (int unsigned i = 1; i < held_count; i++)
          if (hit == 0 && held_ids[i] == key) hit = i;
        if (hit == 0) begin
          o.status = ST_NOT_FOUND;
        end else begin
          o.status     = ST_REMOVED;
          o.removed_id = held_ids[hit-1];
          for (int unsigned i = hit; i < held_count; i++) held_ids[i-1] = held_ids[i];
          held_count--;
        end
      end
      o.entry_count = 6'(held_count);
      pending.push_back(o);
    endfunction

    // Compare one result transaction with the oldest outcome
    function void check_result(input logic [2:0] status, input logic [31:0] removed_id,
                               input logic [5:0] entry_count);
      list_outcome_t o;
      if (pending.size() == 0) begin
        $error("result with nothing outstanding: status %0d removed_id %h entry_count %0d",
               status, removed_id, entry_count);
        errors++;
        return;
      end
      o = pending.pop_front();
      if (status !== o.status) begin
        $error("status: expected %0d, actual %0d", o.status, status);
        errors++;
      end
      if (removed_id !== o.removed_id) begin
        $error("removed_id: expected %h, actual %h", o.removed_id, removed_id);
        errors++;
      end
      if (entry_count !== o.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", o.entry_count, entry_count);
        errors++;
      end
      seen[o.status]++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = KIND_APPEND;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [DATA_O_W-1:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned sent_total     = 0;

  list_scoreboard sb;

  ordered_list_append_delete_before_unit #(
    .DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Stall the result side at random
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every result transaction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[37:32]);
  end

  // Offer one item from a falling edge, return at the falling edge after its transaction
  task automatic send_item(input logic kind, input logic [31:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= key;
    forever begin
      @(posedge clk);
      if (s_axis_tready) break;
    end
    sb.note_item(kind, key);
    sent_total++;
    @(negedge clk);
  endtask

  // Hold the input side quiet until every outcome has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  // Random traffic: tides of mostly appends and mostly deletes,
  // with delete references drawn mostly from the entries held
  task automatic run_random(input int n);
    int unsigned tide;
    bit          growing;
    int unsigned roll;
    logic        kind;
    logic [31:0] key;
    tide    = 0;
    growing = 1'b0;
    repeat (n) begin
      if (tide == 0) begin
        growing = !growing;
        tide    = $urandom_range(15, 60);
      end
      tide--;
      kind = ($urandom_range(99) < (growing ? 80 : 25)) ? KIND_APPEND : KIND_DELETE;
      roll = $urandom_range(99);
      if (kind == KIND_APPEND) begin
        if (roll < 60)
          key = 32'($urandom_range(0, 7)) - 32'd4;
        else if (roll < 85)
          key = $urandom;
        else
          case ($urandom_range(3))
            0: key = 32'h8000_0000;
            1: key = 32'h7FFF_FFFF;
            2: key = 32'h0000_0000;
            default: key = 32'hFFFF_FFFF;
          endcase
      end else begin
        if (roll < 55 && sb.held_count > 1)
          key = sb.held($urandom_range(1, sb.held_count - 1));
        else if (roll < 70 && sb.held_count > 0)
          key = sb.held(0);
        else if (roll < 88)
          key = 32'($urandom_range(0, 7)) - 32'd4;
        else
          key = $urandom;
      end
      send_item(kind, key);
    end
  endtask

  initial begin : stimulus
    sb = new();
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty list, extreme ids, head match, absent reference,
    // duplicates, match at the tail, single entry
    send_item(KIND_DELETE, 32'h0000_0001);
    send_item(KIND_APPEND, 32'h8000_0000);
    send_item(KIND_APPEND, 32'h7FFF_FFFF);
    send_item(KIND_APPEND, 32'h0000_0000);
    send_item(KIND_APPEND, 32'hFFFF_FFFF);
    send_item(KIND_APPEND, 32'h7FFF_FFFF);
    send_item(KIND_DELETE, 32'h8000_0000);
    send_item(KIND_DELETE, 32'h1234_5678);
    send_item(KIND_DELETE, 32'h7FFF_FFFF);
    send_item(KIND_DELETE, 32'h7FFF_FFFF);
    send_item(KIND_DELETE, 32'hFFFF_FFFF);
    send_item(KIND_APPEND, 32'h0000_0005);
    send_item(KIND_DELETE, 32'h0000_0005);
    send_item(KIND_DELETE, 32'hFFFF_FFFF);
    send_item(KIND_DELETE, 32'h0000_0005);
    send_item(KIND_DELETE, 32'h0000_0005);
    send_item(KIND_DELETE, 32'h0000_0009);
    send_item(KIND_APPEND, 32'hA5A5_5A5A);
    send_item(KIND_DELETE, 32'h5A5A_A5A5);
    wait_drained();

    // Random phases: no idling, sender idle, receiver stalling, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      run_random(225);
      wait_drained();
    end

    recv_stall_pct = 0;
    repeat (LIST_DEPTH + 8) @(negedge clk);

    $display("Covered %0d transactions: %0d appended, %0d full, %0d empty,",
             sent_total, sb.seen[ST_APPENDED], sb.seen[ST_FULL], sb.seen[ST_EMPTY]);
    $display("  %0d reference at head, %0d not found, %0d removed.",
             sb.seen[ST_HEAD], sb.seen[ST_NOT_FOUND], sb.seen[ST_REMOVED]);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1600000;
    $display("FAIL");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/olad_pkg.sv
hw/rtl/olad_ctrl.sv
hw/rtl/olad_store.sv
hw/rtl/ordered_list_append_delete_before_unit.sv
sim/testbench.sv
